/* rtl/psmt_pkg.sv */
// Shared types and constants of the PS/2 mouse packet tracker.
package psmt_pkg;

  localparam int CoordBitsDefault = 12;

  localparam int MaxXReset    = 1023;
  localparam int MaxYReset    = 767;
  localparam int CursorResetX = 512;
  localparam int CursorResetY = 384;

  localparam int SyncBit  = 3;
  localparam int SignXBit = 4;
  localparam int SignYBit = 5;
  localparam int ButtonBits = 3;
  localparam int DeltaXBits = 9;
  localparam int DeltaYBits = 10;

  typedef enum logic [1:0] {
    CMD_NOP,
    CMD_BYTE,
    CMD_SET
  } cmd_op_e;

  typedef enum logic [1:0] {
    PHASE_HEADER,
    PHASE_MOVE_X,
    PHASE_MOVE_Y
  } phase_e;

  typedef enum logic [0:0] {
    CFG_MAX_X,
    CFG_MAX_Y
  } cfg_idx_e;

  typedef struct packed {
    cmd_op_e    op;
    logic [7:0] data;
  } cmd_hdr_t;

endpackage

/* rtl/ps2_mouse_packet_tracker_top.sv */
// Top level of the PS/2 mouse packet tracker.
// Each pushed word (controller byte or set-position command) yields exactly one result
// word holding cursor position, buttons, last deltas and a packet-done flag. One word is
// accepted per clock while the two-entry command queue has room; its result passes through
// the command queue and the two-entry result queue before it reaches the result ports, so
// sustained throughput is one word per cycle with pop held high. Bytes without the aux
// flag return the state unchanged, headers without bit 3 set are dropped, and the cursor
// is clamped to 0..max_x and 0..max_y on every packet and set command. Write max_x
// (index 0) and max_y (index 1) only while both queues are empty.
module ps2_mouse_packet_tracker_top #(
  parameter int COORD_BITS = psmt_pkg::CoordBitsDefault
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   push,
  output logic                                   full,
  input  logic                                   func_i,
  input  logic                                   aux_flag_i,
  input  logic [7:0]                             rx_byte_i,
  input  logic [COORD_BITS-1:0]                  set_x_i,
  input  logic [COORD_BITS-1:0]                  set_y_i,
  output logic                                   empty,
  input  logic                                   pop,
  output logic [COORD_BITS-1:0]                  pos_x_o,
  output logic [COORD_BITS-1:0]                  pos_y_o,
  output logic [psmt_pkg::ButtonBits-1:0]        button_bits_o,
  output logic signed [psmt_pkg::DeltaXBits-1:0] delta_x_o,
  output logic signed [psmt_pkg::DeltaYBits-1:0] delta_y_o,
  output logic                                   packet_done_o,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic                                   cfg_index_i,
  input  logic [COORD_BITS-1:0]                  cfg_data_i
);

  logic                  cmd_valid;
  logic                  cmd_pop;
  psmt_pkg::cmd_hdr_t    cmd_hdr;
  logic [COORD_BITS-1:0] cmd_set_x;
  logic [COORD_BITS-1:0] cmd_set_y;

  psmt_front #(
    .CoordBits (COORD_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .func_i      (func_i),
    .aux_flag_i  (aux_flag_i),
    .rx_byte_i   (rx_byte_i),
    .set_x_i     (set_x_i),
    .set_y_i     (set_y_i),
    .cmd_valid_o (cmd_valid),
    .cmd_pop_i   (cmd_pop),
    .cmd_hdr_o   (cmd_hdr),
    .cmd_set_x_o (cmd_set_x),
    .cmd_set_y_o (cmd_set_y)
  );

  psmt_back #(
    .CoordBits (COORD_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (cmd_valid),
    .cmd_pop_o     (cmd_pop),
    .cmd_hdr_i     (cmd_hdr),
    .cmd_set_x_i   (cmd_set_x),
    .cmd_set_y_i   (cmd_set_y),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .empty_o       (empty),
    .pop_i         (pop),
    .pos_x_o       (pos_x_o),
    .pos_y_o       (pos_y_o),
    .button_bits_o (button_bits_o),
    .delta_x_o     (delta_x_o),
    .delta_y_o     (delta_y_o),
    .packet_done_o (packet_done_o)
  );

endmodule

/* rtl/psmt_fifo.sv */
// Two-entry register queue with push/full and pop/empty handshakes.
module psmt_fifo #(
  parameter int Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);

  logic [Width-1:0] mem_q [2];
  logic             wr_ptr_q;
  logic             rd_ptr_q;
  logic [1:0]       cnt_q;
  logic             do_push;
  logic             do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

/* rtl/psmt_front.sv */
// Input side: accept words, classify them and queue commands for the back end.
module psmt_front #(
  parameter int CoordBits = psmt_pkg::CoordBitsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  output logic                 full_o,
  input  logic                 func_i,
  input  logic                 aux_flag_i,
  input  logic [7:0]           rx_byte_i,
  input  logic [CoordBits-1:0] set_x_i,
  input  logic [CoordBits-1:0] set_y_i,
  output logic                 cmd_valid_o,
  input  logic                 cmd_pop_i,
  output psmt_pkg::cmd_hdr_t   cmd_hdr_o,
  output logic [CoordBits-1:0] cmd_set_x_o,
  output logic [CoordBits-1:0] cmd_set_y_o
);

  localparam int CmdW = $bits(psmt_pkg::cmd_hdr_t) + 2 * CoordBits;

  psmt_pkg::cmd_hdr_t hdr;
  logic [CmdW-1:0]    cmd_wdata;
  logic [CmdW-1:0]    cmd_rdata;
  logic               cmd_empty;

  always_comb begin
    hdr.data = rx_byte_i;
    if (func_i) begin
      hdr.op = psmt_pkg::CMD_SET;
    end else if (aux_flag_i) begin
      hdr.op = psmt_pkg::CMD_BYTE;
    end else begin
      hdr.op = psmt_pkg::CMD_NOP;
    end
  end

  assign cmd_wdata = {hdr, set_x_i, set_y_i};

  psmt_fifo #(
    .Width (CmdW)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .wdata_i (cmd_wdata),
    .full_o  (full_o),
    .pop_i   (cmd_pop_i),
    .rdata_o (cmd_rdata),
    .empty_o (cmd_empty)
  );

  assign cmd_valid_o = ~cmd_empty;
  assign {cmd_hdr_o, cmd_set_x_o, cmd_set_y_o} = cmd_rdata;

endmodule

/* rtl/psmt_back.sv */
// Execution side: packet assembly, cursor update and result queue.
module psmt_back #(
  parameter int CoordBits = psmt_pkg::CoordBitsDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cmd_valid_i,
  output logic                              cmd_pop_o,
  input  psmt_pkg::cmd_hdr_t                cmd_hdr_i,
  input  logic [CoordBits-1:0]              cmd_set_x_i,
  input  logic [CoordBits-1:0]              cmd_set_y_i,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic                              cfg_index_i,
  input  logic [CoordBits-1:0]              cfg_data_i,
  output logic                              empty_o,
  input  logic                              pop_i,
  output logic [CoordBits-1:0]              pos_x_o,
  output logic [CoordBits-1:0]              pos_y_o,
  output logic [psmt_pkg::ButtonBits-1:0]   button_bits_o,
  output logic signed [psmt_pkg::DeltaXBits-1:0] delta_x_o,
  output logic signed [psmt_pkg::DeltaYBits-1:0] delta_y_o,
  output logic                              packet_done_o
);

  localparam int SumW = CoordBits + 2;
  localparam int ResW = 2 * CoordBits + psmt_pkg::ButtonBits + psmt_pkg::DeltaXBits
                        + psmt_pkg::DeltaYBits + 1;
  localparam logic [CoordBits-1:0] MaxXRst = CoordBits'(psmt_pkg::MaxXReset);
  localparam logic [CoordBits-1:0] MaxYRst = CoordBits'(psmt_pkg::MaxYReset);
  localparam logic [CoordBits-1:0] CurXRst = CoordBits'(psmt_pkg::CursorResetX);
  localparam logic [CoordBits-1:0] CurYRst = CoordBits'(psmt_pkg::CursorResetY);

  psmt_pkg::phase_e                     phase_q, phase_d;
  logic [7:0]                           header_q, header_d;
  logic [7:0]                           move_x_q, move_x_d;
  logic [CoordBits-1:0]                 cursor_x_q, cursor_x_d;
  logic [CoordBits-1:0]                 cursor_y_q, cursor_y_d;
  logic [psmt_pkg::ButtonBits-1:0]      buttons_q, buttons_d;
  logic signed [psmt_pkg::DeltaXBits-1:0] dx_q, dx_d;
  logic signed [psmt_pkg::DeltaYBits-1:0] dy_q, dy_d;
  logic [CoordBits-1:0]                 max_x_q;
  logic [CoordBits-1:0]                 max_y_q;
  logic                                 done;

  logic signed [psmt_pkg::DeltaXBits-1:0] dx_new;
  logic signed [psmt_pkg::DeltaYBits-1:0] dy_raw;
  logic signed [psmt_pkg::DeltaYBits-1:0] dy_new;
  logic signed [SumW-1:0]               sum_x;
  logic signed [SumW-1:0]               sum_y;

  logic            res_full;
  logic [ResW-1:0] res_wdata;
  logic [ResW-1:0] res_rdata;

  function automatic logic [CoordBits-1:0] clamp_coord(input logic signed [SumW-1:0] v,
                                                       input logic [CoordBits-1:0] hi);
    logic [CoordBits-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > $signed({2'b00, hi})) begin
      r = hi;
    end else begin
      r = v[CoordBits-1:0];
    end
    return r;
  endfunction

  assign cmd_pop_o   = cmd_valid_i & ~res_full;
  assign cfg_ready_o = 1'b1;

  assign dx_new = {header_q[psmt_pkg::SignXBit], move_x_q};
  assign dy_raw = {{2{header_q[psmt_pkg::SignYBit]}}, cmd_hdr_i.data};
  assign dy_new = -dy_raw;
  assign sum_x  = $signed({2'b00, cursor_x_q}) + SumW'(dx_new);
  assign sum_y  = $signed({2'b00, cursor_y_q}) + SumW'(dy_new);

  always_comb begin
    phase_d    = phase_q;
    header_d   = header_q;
    move_x_d   = move_x_q;
    cursor_x_d = cursor_x_q;
    cursor_y_d = cursor_y_q;
    buttons_d  = buttons_q;
    dx_d       = dx_q;
    dy_d       = dy_q;
    done       = 1'b0;
    if (cmd_pop_o) begin
      unique case (cmd_hdr_i.op)
        psmt_pkg::CMD_SET: begin
          cursor_x_d = (cmd_set_x_i > max_x_q) ? max_x_q : cmd_set_x_i;
          cursor_y_d = (cmd_set_y_i > max_y_q) ? max_y_q : cmd_set_y_i;
          buttons_d  = '0;
          dx_d       = '0;
          dy_d       = '0;
        end
        psmt_pkg::CMD_BYTE: begin
          unique case (phase_q)
            psmt_pkg::PHASE_MOVE_X: begin
              move_x_d = cmd_hdr_i.data;
              phase_d  = psmt_pkg::PHASE_MOVE_Y;
            end
            psmt_pkg::PHASE_MOVE_Y: begin
              buttons_d  = header_q[psmt_pkg::ButtonBits-1:0];
              dx_d       = dx_new;
              dy_d       = dy_new;
              cursor_x_d = clamp_coord(sum_x, max_x_q);
              cursor_y_d = clamp_coord(sum_y, max_y_q);
              phase_d    = psmt_pkg::PHASE_HEADER;
              done       = 1'b1;
            end
            default: begin
              if (cmd_hdr_i.data[psmt_pkg::SyncBit]) begin
                header_d = cmd_hdr_i.data;
                phase_d  = psmt_pkg::PHASE_MOVE_X;
              end else begin
                phase_d  = psmt_pkg::PHASE_HEADER;
              end
            end
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= psmt_pkg::PHASE_HEADER;
      header_q   <= '0;
      move_x_q   <= '0;
      cursor_x_q <= CurXRst;
      cursor_y_q <= CurYRst;
      buttons_q  <= '0;
      dx_q       <= '0;
      dy_q       <= '0;
    end else begin
      phase_q    <= phase_d;
      header_q   <= header_d;
      move_x_q   <= move_x_d;
      cursor_x_q <= cursor_x_d;
      cursor_y_q <= cursor_y_d;
      buttons_q  <= buttons_d;
      dx_q       <= dx_d;
      dy_q       <= dy_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_x_q <= MaxXRst;
      max_y_q <= MaxYRst;
    end else if (cfg_valid_i) begin
      unique case (psmt_pkg::cfg_idx_e'(cfg_index_i))
        psmt_pkg::CFG_MAX_X: max_x_q <= cfg_data_i;
        psmt_pkg::CFG_MAX_Y: max_y_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign res_wdata = {cursor_x_d, cursor_y_d, buttons_d, dx_d, dy_d, done};

  psmt_fifo #(
    .Width (ResW)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_pop_o),
    .wdata_i (res_wdata),
    .full_o  (res_full),
    .pop_i   (pop_i),
    .rdata_o (res_rdata),
    .empty_o (empty_o)
  );

  assign {pos_x_o, pos_y_o, button_bits_o, delta_x_o, delta_y_o, packet_done_o} = res_rdata;

  a_done_from_move_y: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_pop_o && done) |->
    (phase_q == psmt_pkg::PHASE_MOVE_Y && cmd_hdr_i.op == psmt_pkg::CMD_BYTE))
    else $error("packet completed outside the third byte");

  a_cursor_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_pop_o |=> ($stable(cursor_x_q) && $stable(cursor_y_q) && $stable(phase_q)))
    else $error("state changed without a command");

  a_set_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_pop_o && cmd_hdr_i.op == psmt_pkg::CMD_SET) |=>
    (buttons_q == '0 && dx_q == '0 && dy_q == '0))
    else $error("set position left buttons or deltas");

  a_cursor_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_pop_o && done) |=> (cursor_x_q <= max_x_q && cursor_y_q <= max_y_q))
    else $error("cursor beyond bound after packet");

endmodule
